@@ rtl/dfcc_pkg.sv @@
// ----------------------------------------------------------------------------
// dfcc_pkg: shared types and microcode for the double first cousin checker
// Entry format, memory request structs, sequencer steps and the control store.
// ----------------------------------------------------------------------------
package dfcc_pkg;

  localparam int DFCC_ANIMALS = 4096;
  localparam int IDX_W        = 12;
  localparam int PAR_W        = 13;

  // A parent field is either a known index (bit 12 clear) or all ones.
  localparam logic [PAR_W-1:0] PAR_UNKNOWN = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [PAR_W-1:0] par_t;

  typedef struct packed {
    par_t dam;
    par_t sire;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    entry_t           data;
  } mem_wr_t;

  typedef struct packed {
    logic [IDX_W-1:0] a_idx;
    logic [IDX_W-1:0] b_idx;
  } mem_rd_t;

  typedef enum logic [3:0] {
    ST_FETCH,
    ST_RD_PAIR,
    ST_LAT_PAR,
    ST_CHK_PAR,
    ST_LAT_GD,
    ST_LAT_GS,
    ST_CHK_GP,
    ST_CAN_A,
    ST_CAN_B,
    ST_EMIT
  } step_t;

  typedef enum logic [2:0] {
    RD_NONE,
    RD_PAIR,
    RD_P01,
    RD_P23,
    RD_G01,
    RD_G23
  } rd_sel_t;

  typedef enum logic [2:0] {
    LAT_NONE,
    LAT_PAR,
    LAT_GD,
    LAT_GS,
    LAT_MATCH,
    LAT_CAN_A,
    LAT_CAN_B
  } lat_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_QUERY,
    COND_PAR_FAIL,
    COND_NO_EXACT,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    rd_sel_t rd_sel;
    lat_t    lat;
    cond_t   cond;
    logic    take;
    logic    emit;
    step_t   nxt;
    step_t   jmp;
  } ctl_t;

  // Control store: one word per step. A taken condition goes to jmp,
  // otherwise the sequencer moves to nxt.
  function automatic ctl_t ucode(step_t s);
    ctl_t c;
    c = '{rd_sel: RD_NONE, lat: LAT_NONE, cond: COND_NEVER, take: 1'b0,
          emit: 1'b0, nxt: ST_FETCH, jmp: ST_FETCH};
    case (s)
      ST_FETCH: begin
        c.take = 1'b1;
        c.cond = COND_NO_QUERY;
        c.jmp  = ST_FETCH;
        c.nxt  = ST_RD_PAIR;
      end
      ST_RD_PAIR: begin
        c.rd_sel = RD_PAIR;
        c.nxt    = ST_LAT_PAR;
      end
      ST_LAT_PAR: begin
        c.lat = LAT_PAR;
        c.nxt = ST_CHK_PAR;
      end
      ST_CHK_PAR: begin
        c.rd_sel = RD_P01;
        c.cond   = COND_PAR_FAIL;
        c.jmp    = ST_EMIT;
        c.nxt    = ST_LAT_GD;
      end
      ST_LAT_GD: begin
        c.rd_sel = RD_P23;
        c.lat    = LAT_GD;
        c.nxt    = ST_LAT_GS;
      end
      ST_LAT_GS: begin
        c.lat = LAT_GS;
        c.nxt = ST_CHK_GP;
      end
      ST_CHK_GP: begin
        c.rd_sel = RD_G01;
        c.lat    = LAT_MATCH;
        c.cond   = COND_NO_EXACT;
        c.jmp    = ST_EMIT;
        c.nxt    = ST_CAN_A;
      end
      ST_CAN_A: begin
        c.rd_sel = RD_G23;
        c.lat    = LAT_CAN_A;
        c.nxt    = ST_CAN_B;
      end
      ST_CAN_B: begin
        c.lat = LAT_CAN_B;
        c.nxt = ST_EMIT;
      end
      ST_EMIT: begin
        c.emit = 1'b1;
        c.cond = COND_OUT_BUSY;
        c.jmp  = ST_EMIT;
        c.nxt  = ST_FETCH;
      end
      default: begin
        c.nxt = ST_FETCH;
      end
    endcase
    return c;
  endfunction

  function automatic logic has_parent(entry_t e);
    return !e.dam[PAR_W-1] || !e.sire[PAR_W-1];
  endfunction

endpackage

@@ rtl/dfcc_if.sv @@
// ----------------------------------------------------------------------------
// dfcc_if: channel interfaces of the double first cousin checker
// Item, result and configuration channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface dfcc_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [11:0]        first_animal;
  logic [11:0]        second_animal;
  logic signed [12:0] mother_index;
  logic signed [12:0] father_index;
  logic               last_query;

  modport source (output valid, cmd, first_animal, second_animal, mother_index,
                  father_index, last_query, input ready);
  modport sink   (input valid, cmd, first_animal, second_animal, mother_index,
                  father_index, last_query, output ready);
endinterface

interface dfcc_out_if;
  logic valid;
  logic ready;
  logic is_double_cousin;
  logic last_answer;

  modport source (output valid, is_double_cousin, last_answer, input ready);
  modport sink   (input valid, is_double_cousin, last_answer, output ready);
endinterface

interface dfcc_cfg_if;
  logic valid;
  logic ready;
  logic exact_mode;

  modport source (output valid, exact_mode, input ready);
  modport sink   (input valid, exact_mode, output ready);
endinterface

@@ rtl/dfcc_pedigree_mem.sv @@
// ----------------------------------------------------------------------------
// dfcc_pedigree_mem: pedigree table
// One write port and two registered read ports; animals past the table read
// as having an unknown dam and sire.
// ----------------------------------------------------------------------------
module dfcc_pedigree_mem #(
  parameter int ANIMALS = dfcc_pkg::DFCC_ANIMALS
) (
  input  logic             clk,
  input  dfcc_pkg::mem_wr_t wr,
  input  dfcc_pkg::mem_rd_t rd,
  output dfcc_pkg::entry_t  rd_a,
  output dfcc_pkg::entry_t  rd_b
);
  import dfcc_pkg::*;

  localparam int AW = (ANIMALS > 1) ? $clog2(ANIMALS) : 1;

  entry_t mem [ANIMALS];
  entry_t a_data_r;
  entry_t b_data_r;
  logic   a_hit_r;
  logic   b_hit_r;

  function automatic logic in_table(logic [IDX_W-1:0] idx);
    return 32'(idx) < 32'(ANIMALS);
  endfunction

  always_ff @(posedge clk) begin
    if (wr.en && in_table(wr.idx)) begin
      mem[AW'(wr.idx)] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    a_data_r <= mem[AW'(rd.a_idx)];
    b_data_r <= mem[AW'(rd.b_idx)];
    a_hit_r  <= in_table(rd.a_idx);
    b_hit_r  <= in_table(rd.b_idx);
  end

  assign rd_a = a_hit_r ? a_data_r : '{dam: PAR_UNKNOWN, sire: PAR_UNKNOWN};
  assign rd_b = b_hit_r ? b_data_r : '{dam: PAR_UNKNOWN, sire: PAR_UNKNOWN};

endmodule

@@ rtl/double_first_cousin_check_unit.sv @@
// ----------------------------------------------------------------------------
// double_first_cousin_check_unit: pedigree table with double first cousin test
// A load beat writes the dam and sire of one animal. A query beat walks
// parents, grandparents and, in exact mode, the grandparents' parents through
// the table's two read ports under a small microcoded sequencer, and returns
// one result beat. A query is shortest when a parent test fails, longer when
// the grandparent test decides, and longest when the exact-mode check runs;
// each lookup level costs a registered table read. The result sits in an
// output register, so the next item is taken while a result still waits.
// ----------------------------------------------------------------------------
module double_first_cousin_check_unit #(
  parameter int ANIMALS = dfcc_pkg::DFCC_ANIMALS
) (
  input logic        clk,
  input logic        rst_n,
  dfcc_cfg_if.sink   cfg_bus,
  dfcc_in_if.sink    in_bus,
  dfcc_out_if.source out_bus
);
  import dfcc_pkg::*;

  step_t   step_r;
  step_t   step_nxt;
  ctl_t    ctl;
  logic    jump;

  logic    exact_mode_r;
  logic [IDX_W-1:0] first_r;
  logic [IDX_W-1:0] second_r;
  logic    last_r;

  par_t    p_r [4];
  par_t    g_r [8];
  logic    res_r;
  logic    cancel_r;

  logic    out_valid_r;
  logic    out_double_r;
  logic    out_last_r;

  logic    in_beat;
  logic    query_beat;
  logic    out_load;
  logic    par_fail;
  logic    gp_known;
  logic    straight;
  logic    crossed;
  logic    match;

  mem_wr_t wr;
  mem_rd_t rd;
  entry_t  rd_a;
  entry_t  rd_b;

  dfcc_pedigree_mem #(.ANIMALS(ANIMALS)) u_mem (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  assign ctl        = ucode(step_r);
  assign in_beat    = in_bus.valid && in_bus.ready;
  assign query_beat = in_beat && (in_bus.cmd == CMD_QUERY);

  // Pair and grandparent tests on the latched pedigree.
  assign par_fail = p_r[0][PAR_W-1] || p_r[1][PAR_W-1] || p_r[2][PAR_W-1] ||
                    p_r[3][PAR_W-1] || (p_r[0] == p_r[2]) || (p_r[1] == p_r[3]);

  always_comb begin
    gp_known = 1'b1;
    for (int k = 0; k < 8; k++) begin
      if (g_r[k][PAR_W-1]) begin
        gp_known = 1'b0;
      end
    end
  end

  assign straight = (g_r[0] == g_r[4]) && (g_r[1] == g_r[5]) &&
                    (g_r[2] == g_r[6]) && (g_r[3] == g_r[7]);
  assign crossed  = (g_r[0] == g_r[6]) && (g_r[1] == g_r[7]) &&
                    (g_r[2] == g_r[4]) && (g_r[3] == g_r[5]);
  assign match    = gp_known && (straight || crossed);

  // Next step.
  always_comb begin
    case (ctl.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_QUERY: jump = !query_beat;
      COND_PAR_FAIL: jump = par_fail;
      COND_NO_EXACT: jump = !(match && exact_mode_r);
      COND_OUT_BUSY: jump = out_valid_r && !out_bus.ready;
      default:       jump = 1'b0;
    endcase
    step_nxt = jump ? ctl.jmp : ctl.nxt;
  end

  // Control word decode.
  always_comb begin
    in_bus.ready = ctl.take;
    out_load     = ctl.emit && (!out_valid_r || out_bus.ready);

    wr.en        = in_beat && (in_bus.cmd == CMD_LOAD);
    wr.idx       = in_bus.first_animal;
    wr.data.dam  = in_bus.mother_index[PAR_W-1] ? PAR_UNKNOWN : in_bus.mother_index;
    wr.data.sire = in_bus.father_index[PAR_W-1] ? PAR_UNKNOWN : in_bus.father_index;

    case (ctl.rd_sel)
      RD_PAIR: begin
        rd.a_idx = first_r;
        rd.b_idx = second_r;
      end
      RD_P01: begin
        rd.a_idx = p_r[0][IDX_W-1:0];
        rd.b_idx = p_r[1][IDX_W-1:0];
      end
      RD_P23: begin
        rd.a_idx = p_r[2][IDX_W-1:0];
        rd.b_idx = p_r[3][IDX_W-1:0];
      end
      RD_G01: begin
        rd.a_idx = g_r[0][IDX_W-1:0];
        rd.b_idx = g_r[1][IDX_W-1:0];
      end
      RD_G23: begin
        rd.a_idx = g_r[2][IDX_W-1:0];
        rd.b_idx = g_r[3][IDX_W-1:0];
      end
      default: begin
        rd.a_idx = '0;
        rd.b_idx = '0;
      end
    endcase
  end

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= ST_FETCH;
      exact_mode_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_bus.valid && cfg_bus.ready) begin
        exact_mode_r <= cfg_bus.exact_mode;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (query_beat) begin
      first_r  <= in_bus.first_animal;
      second_r <= in_bus.second_animal;
      last_r   <= in_bus.last_query;
    end
    case (ctl.lat)
      LAT_PAR: begin
        p_r[0] <= rd_a.dam;
        p_r[1] <= rd_a.sire;
        p_r[2] <= rd_b.dam;
        p_r[3] <= rd_b.sire;
        res_r  <= 1'b0;
      end
      LAT_GD: begin
        g_r[0] <= rd_a.dam;
        g_r[1] <= rd_a.sire;
        g_r[2] <= rd_b.dam;
        g_r[3] <= rd_b.sire;
      end
      LAT_GS: begin
        g_r[4] <= rd_a.dam;
        g_r[5] <= rd_a.sire;
        g_r[6] <= rd_b.dam;
        g_r[7] <= rd_b.sire;
      end
      LAT_MATCH: begin
        res_r <= match;
      end
      LAT_CAN_A: begin
        cancel_r <= has_parent(rd_a) || has_parent(rd_b);
      end
      LAT_CAN_B: begin
        // Matched grandparents are equal, so any known parent of the first
        // animal's grandparents is a shared great-grandparent.
        res_r <= res_r && !(cancel_r || has_parent(rd_a) || has_parent(rd_b));
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_double_r <= res_r;
      out_last_r   <= last_r;
    end
  end

  assign out_bus.valid            = out_valid_r;
  assign out_bus.is_double_cousin = out_double_r;
  assign out_bus.last_answer      = out_last_r;

`ifndef SYNTH
  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && (in_bus.cmd == CMD_LOAD) && !out_valid_r) |=> !out_valid_r)
    else $error("load beat produced a result");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    query_beat |=> (step_r == ST_RD_PAIR))
    else $error("query beat did not start the lookup program");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_EMIT && (!out_valid_r || out_bus.ready)) |=>
      (out_valid_r && step_r == ST_FETCH))
    else $error("result not registered on leaving the emit step");

  a_hit_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_EMIT && res_r) |-> (p_r[0] != p_r[2] && p_r[1] != p_r[3]))
    else $error("positive answer with a shared parent");
`endif

endmodule

@@ bench/double_first_cousin_check_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_first_cousin_check_unit_tb: self-checking bench for the cousin checker
// Fills a pool of animals in the pedigree table, then drives directed and
// random load and query beats; the random beats stay inside that pool. Most
// of the random stimulus builds complete two-generation families, straight or
// crossed, some of them with a flaw added afterwards. An in-bench model of the
// table predicts each answer, and the answers are checked in order under random
// stalls on both channels, with exact mode toggled between phases.
// ----------------------------------------------------------------------------
module double_first_cousin_check_unit_tb;
  import dfcc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int ANIMAL_POOL  = 64;

  typedef logic signed [PAR_W-1:0] parent_code_t;

  typedef struct {
    logic             cmd;
    logic [IDX_W-1:0] first_animal;
    logic [IDX_W-1:0] second_animal;
    parent_code_t     mother_index;
    parent_code_t     father_index;
    logic             last_query;
  } pedigree_beat_t;

  typedef struct {
    logic is_double_cousin;
    logic last_answer;
  } cousin_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  dfcc_in_if  in_bus ();
  dfcc_out_if out_bus ();
  dfcc_cfg_if cfg_bus ();

  double_first_cousin_check_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_bus (cfg_bus),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #5 clk = ~clk;

  // Local copy of the pedigree table and the mode register.
  parent_code_t dam_tbl [DFCC_ANIMALS];
  parent_code_t sire_tbl [DFCC_ANIMALS];
  logic         exact_mode_q;

  pedigree_beat_t pending_beats [$];
  cousin_answer_t expected_answers [$];
  pedigree_beat_t offered_beat;

  int unsigned beats_queued;
  int unsigned beats_taken;
  int unsigned answers_seen;
  int unsigned mismatches;
  int unsigned cycle_count;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          hold_requests;
  int          hold_served;
  int          hold_left;
  logic        in_beat_taken;

  function automatic parent_code_t as_parent(logic [IDX_W-1:0] animal);
    return parent_code_t'({1'b0, animal});
  endfunction

  // Any negative code means an unknown parent.
  function automatic parent_code_t unknown_code();
    return parent_code_t'($urandom_range(8191, 4096));
  endfunction

  // Known parents always come from the pool, so every lookup hits a loaded entry.
  function automatic parent_code_t known_code();
    return parent_code_t'($urandom_range(ANIMAL_POOL - 1, 0));
  endfunction

  function automatic parent_code_t random_parent();
    return ($urandom_range(3) == 0) ? unknown_code() : known_code();
  endfunction

  function automatic logic [IDX_W-1:0] pick_animal();
    return IDX_W'($urandom_range(ANIMAL_POOL - 1, 0));
  endfunction

  function automatic bit line_shared(parent_code_t x, parent_code_t y);
    parent_code_t xd;
    parent_code_t xs;
    xd = dam_tbl[x[IDX_W-1:0]];
    xs = sire_tbl[x[IDX_W-1:0]];
    return (xd >= 0 && xd == dam_tbl[y[IDX_W-1:0]]) ||
           (xs >= 0 && xs == sire_tbl[y[IDX_W-1:0]]);
  endfunction

  function automatic logic cousin_verdict(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b);
    parent_code_t pa [2];
    parent_code_t pb [2];
    parent_code_t ga [4];
    parent_code_t gb [4];
    bit           straight;
    bit           crossed;
    bit           cut_straight;
    bit           cut_crossed;
    int           k;
    pa[0] = dam_tbl[a];
    pa[1] = sire_tbl[a];
    pb[0] = dam_tbl[b];
    pb[1] = sire_tbl[b];
    if (pa[0] < 0 || pa[1] < 0 || pb[0] < 0 || pb[1] < 0 ||
        pa[0] == pb[0] || pa[1] == pb[1]) begin
      return 1'b0;
    end
    for (k = 0; k < 4; k++) begin
      ga[k] = k[0] ? sire_tbl[pa[k>>1][IDX_W-1:0]] : dam_tbl[pa[k>>1][IDX_W-1:0]];
      gb[k] = k[0] ? sire_tbl[pb[k>>1][IDX_W-1:0]] : dam_tbl[pb[k>>1][IDX_W-1:0]];
    end
    for (k = 0; k < 4; k++) begin
      if (ga[k] < 0 || gb[k] < 0) begin
        return 1'b0;
      end
    end
    // The crossed order pairs the dam side of one animal with the sire side
    // of the other, which is index k^2 in grandparent order.
    straight = 1'b1;
    crossed  = 1'b1;
    for (k = 0; k < 4; k++) begin
      if (ga[k] != gb[k]) straight = 1'b0;
      if (ga[k] != gb[k^2]) crossed = 1'b0;
    end
    if (exact_mode_q) begin
      cut_straight = 1'b0;
      cut_crossed  = 1'b0;
      for (k = 0; k < 4; k++) begin
        if (line_shared(ga[k], gb[k])) cut_straight = 1'b1;
        if (line_shared(ga[k], gb[k^2])) cut_crossed = 1'b1;
      end
      straight = straight && !cut_straight;
      crossed  = crossed && !cut_crossed;
    end
    return straight || crossed;
  endfunction

  task automatic queue_beat(input pedigree_beat_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic queue_load(input logic [IDX_W-1:0] animal, input parent_code_t mom,
                            input parent_code_t dad);
    pedigree_beat_t b;
    b.cmd           = CMD_LOAD;
    b.first_animal  = animal;
    b.second_animal = IDX_W'($urandom);
    b.mother_index  = mom;
    b.father_index  = dad;
    b.last_query    = 1'($urandom);
    queue_beat(b);
  endtask

  task automatic queue_query(input logic [IDX_W-1:0] a, input logic [IDX_W-1:0] b,
                             input logic last_flag);
    pedigree_beat_t q;
    q.cmd           = CMD_QUERY;
    q.first_animal  = a;
    q.second_animal = b;
    q.mother_index  = parent_code_t'($urandom);
    q.father_index  = parent_code_t'($urandom);
    q.last_query    = last_flag;
    queue_beat(q);
  endtask

  // Builds two children whose grandparents match side for side or crossed,
  // queries them, and optionally breaks the family and queries again.
  // ids: 0..3 grandparents, 4..5 first child's dam and sire, 6..7 second
  // child's dam and sire, 8..9 the children.
  task automatic queue_family(input bit crossed, input bit twin_lines, input bit deep_known,
                              input int flaw);
    logic [IDX_W-1:0] ids [10];
    logic [IDX_W-1:0] cand;
    bit               clash;
    int               n;
    int               k;
    n = 0;
    while (n < 10) begin
      cand  = pick_animal();
      clash = 1'b0;
      for (k = 0; k < n; k++) begin
        if (ids[k] == cand) clash = 1'b1;
      end
      if (!clash) begin
        ids[n] = cand;
        n++;
      end
    end
    if (twin_lines) begin
      ids[2] = ids[0];
      ids[3] = ids[1];
    end
    for (k = 0; k < (twin_lines ? 2 : 4); k++) begin
      if (deep_known) begin
        queue_load(ids[k], (k == 0 || $urandom_range(1)) ? known_code() : unknown_code(),
                   $urandom_range(1) ? known_code() : unknown_code());
      end else begin
        queue_load(ids[k], unknown_code(), unknown_code());
      end
    end
    queue_load(ids[4], as_parent(ids[0]), as_parent(ids[1]));
    queue_load(ids[5], as_parent(ids[2]), as_parent(ids[3]));
    if (crossed) begin
      queue_load(ids[6], as_parent(ids[2]), as_parent(ids[3]));
      queue_load(ids[7], as_parent(ids[0]), as_parent(ids[1]));
    end else begin
      queue_load(ids[6], as_parent(ids[0]), as_parent(ids[1]));
      queue_load(ids[7], as_parent(ids[2]), as_parent(ids[3]));
    end
    queue_load(ids[8], as_parent(ids[4]), as_parent(ids[5]));
    queue_load(ids[9], as_parent(ids[6]), as_parent(ids[7]));
    queue_query(ids[8], ids[9], 1'($urandom));
    if ($urandom_range(1)) queue_query(ids[9], ids[8], 1'($urandom));
    case (flaw)
      1: queue_load(ids[9], as_parent(ids[4]), as_parent(ids[7]));  // shared dam
      2: queue_load(ids[7], unknown_code(), as_parent(ids[3]));     // lost grandparent
      3: queue_load(ids[6], known_code(), as_parent(ids[1]));       // one grandparent swapped
      4: queue_load(ids[8], as_parent(ids[4]), unknown_code());     // unknown sire
      default: ;
    endcase
    if (flaw != 0) queue_query(ids[8], ids[9], 1'($urandom));
  endtask

  task automatic queue_random_mix(input int beats);
    int unsigned goal;
    int          r;
    logic [IDX_W-1:0] a;
    goal = beats_queued + beats;
    while (beats_queued < goal) begin
      r = $urandom_range(99);
      if (r < 60) begin
        queue_family($urandom_range(1), $urandom_range(3) == 0, $urandom_range(1),
                     ($urandom_range(2) == 0) ? $urandom_range(4, 1) : 0);
      end else if (r < 80) begin
        queue_load(pick_animal(), random_parent(), random_parent());
      end else begin
        a = pick_animal();
        queue_query(a, ($urandom_range(3) == 0) ? a : pick_animal(), 1'($urandom));
      end
    end
  endtask

  task automatic set_exact_mode(input logic mode);
    @(negedge clk);
    cfg_bus.valid      <= 1'b1;
    cfg_bus.exact_mode <= mode;
    do @(posedge clk); while (!cfg_bus.ready);
    exact_mode_q = mode;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // Loads give no result, so the bench also waits out DRAIN_CYCLES after the
  // last answer before the block is taken as idle.
  task automatic wait_for_idle();
    while (beats_taken != beats_queued || expected_answers.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic flag_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR: %s", msg);
  endtask

  // Input side: offer a new beat once the previous one has gone.
  always @(negedge clk) begin
    if (!in_bus.valid || in_beat_taken) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_beat = pending_beats.pop_front();
        in_bus.valid         <= 1'b1;
        in_bus.cmd           <= offered_beat.cmd;
        in_bus.first_animal  <= offered_beat.first_animal;
        in_bus.second_animal <= offered_beat.second_animal;
        in_bus.mother_index  <= offered_beat.mother_index;
        in_bus.father_index  <= offered_beat.father_index;
        in_bus.last_query    <= offered_beat.last_query;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
    in_beat_taken = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Accepted input beats update the table copy or queue an expected answer.
  always @(posedge clk) begin
    if (rst_n && in_bus.valid && in_bus.ready) begin
      in_beat_taken = 1'b1;
      beats_taken++;
      if (in_bus.cmd == CMD_LOAD) begin
        dam_tbl[in_bus.first_animal] =
          (in_bus.mother_index < 0) ? parent_code_t'(PAR_UNKNOWN) : in_bus.mother_index;
        sire_tbl[in_bus.first_animal] =
          (in_bus.father_index < 0) ? parent_code_t'(PAR_UNKNOWN) : in_bus.father_index;
      end else begin
        expected_answers.push_back('{
          is_double_cousin: cousin_verdict(in_bus.first_animal, in_bus.second_animal),
          last_answer:      in_bus.last_query});
      end
    end
  end

  always @(posedge clk) begin
    cousin_answer_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      answers_seen++;
      if (expected_answers.size() == 0) begin
        flag_error($sformatf("answer beat %0d arrived with nothing expected", answers_seen));
      end else begin
        want = expected_answers.pop_front();
        if (out_bus.is_double_cousin !== want.is_double_cousin)
          flag_error($sformatf("answer %0d is_double_cousin: expected %b, got %b",
                               answers_seen, want.is_double_cousin, out_bus.is_double_cousin));
        if (out_bus.last_answer !== want.last_answer)
          flag_error($sformatf("answer %0d last_answer: expected %b, got %b",
                               answers_seen, want.last_answer, out_bus.last_answer));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int animal;
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.cmd           = CMD_LOAD;
    in_bus.first_animal  = '0;
    in_bus.second_animal = '0;
    in_bus.mother_index  = '0;
    in_bus.father_index  = '0;
    in_bus.last_query    = 1'b0;
    out_bus.ready        = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.exact_mode   = 1'b0;
    exact_mode_q         = 1'b0;
    in_beat_taken        = 1'b0;
    beats_queued         = 0;
    beats_taken          = 0;
    answers_seen         = 0;
    mismatches           = 0;
    cycle_count          = 0;
    hold_requests        = 0;
    hold_served          = 0;
    hold_left            = 0;
    send_idle_pct        = 11;
    recv_idle_pct        = 78;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    set_exact_mode(1'b0);

    // Every animal of the pool is written once up front. Later random stimulus
    // names only pool animals, and the directed beats load the one animal outside
    // it before querying it, so no lookup ever hits an entry that was never loaded.
    for (animal = 0; animal < ANIMAL_POOL; animal++) begin
      queue_load(IDX_W'(animal),
                 $urandom_range(9) < 3 ? unknown_code() : known_code(),
                 $urandom_range(9) < 3 ? unknown_code() : known_code());
    end
    wait_for_idle();

    // Field extremes, the most negative unknown code, and same-animal pairs.
    queue_load(IDX_W'(DFCC_ANIMALS - 1), as_parent(IDX_W'(DFCC_ANIMALS - 1)), as_parent('0));
    queue_load('0, parent_code_t'(13'h1000), parent_code_t'(PAR_UNKNOWN));
    queue_query('0, IDX_W'(DFCC_ANIMALS - 1), 1'b1);
    queue_query(IDX_W'(DFCC_ANIMALS - 1), IDX_W'(DFCC_ANIMALS - 1), 1'b0);
    // A clean straight family, then the second child moved onto the same dam.
    queue_family(1'b0, 1'b0, 1'b0, 1);
    wait_for_idle();

    set_exact_mode(1'b1);
    queue_random_mix(100);
    wait_for_idle();

    send_idle_pct = 78;
    recv_idle_pct = 11;
    set_exact_mode(1'b0);
    queue_random_mix(100);
    wait_for_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_exact_mode(1'b1);
    // Back-to-back queries while the result side holds off fill the block.
    hold_requests++;
    repeat (6) queue_query(pick_animal(), pick_animal(), 1'($urandom));
    queue_random_mix(100);
    wait_for_idle();

    if (expected_answers.size() != 0)
      flag_error($sformatf("%0d answers never arrived", expected_answers.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/dfcc_pkg.sv
rtl/dfcc_if.sv
rtl/dfcc_pedigree_mem.sv
rtl/double_first_cousin_check_unit.sv
bench/double_first_cousin_check_unit_tb.sv
